// ----- design/skt_pkg.sv -----
// Shared types and codes for the sorted key table.
// Used by skt_cell and sorted_key_table; depends on nothing else.
package skt_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 3'd0,
        CMD_FORCE_ADD = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_SEEK      = 3'd3,
        CMD_PEEK      = 3'd4,
        CMD_TELL      = 3'd5,
        CMD_CLEAR     = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_EQ_KEY    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_NO_ENTRY  = 3'd5
    } t_status;

    // Per-cell update selected by the controller.
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_LOAD  = 3'd1,
        CELL_LEFT  = 3'd2,
        CELL_RIGHT = 3'd3,
        CELL_CLEAR = 3'd4,
        CELL_SEEK  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cur;
    } t_cell_ctl;

    // Compare results of one cell against the broadcast handle and key.
    typedef struct packed {
        logic ge;
        logic heq;
        logic keq;
    } t_cell_flags;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

endpackage

// ----- design/sorted_key_table.sv -----
// Sorted key table: a row of DEPTH cells holding (handle, key) entries in
// ascending key order, with a one-entry cursor. Depends on skt_pkg, skt_cell.
//
// Usage: one command item enters on the input channel (i_valid / o_ready)
// and exactly one result item leaves on the output channel (o_valid /
// i_ready). Add and force add shift the entries at and above the insertion
// point up by one cell; remove shifts the entries above the removed one
// down. Seek, peek and tell read one entry through the cursor; clear empties
// the table. Every result carries the entry count after the command.
// Timing: an item is accepted in the idle state, every cell compares its
// entry with the item in the next cycle (compare state), and in the apply
// state that follows the flags are combined, the cells are updated and
// the result is registered. A new item is taken only once the table is
// back in the idle state after the apply state; the compare stage followed
// by the update stage of the cell row sets this order.
// If the receiver stalls with a result still held, the next item waits in
// the compare stage and no cell is changed until the output is free.
// Reset (synchronous, active low) empties the table and clears the cursor;
// the entry storage itself is not cleared.
module sorted_key_table import skt_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int KEY_W    = 32,
    parameter int HANDLE_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [CMD_W-1:0]             i_command,
    input  logic [HANDLE_W-1:0]          i_handle,
    input  logic [KEY_W-1:0]             i_sort_key,
    input  logic signed [POS_W-1:0]      i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [STATUS_W-1:0]          o_status,
    output logic [HANDLE_W-1:0]          o_handle_out,
    output logic [KEY_W-1:0]             o_key_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = IW + 1;

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [HANDLE_W-1:0]   r_handle;
    logic [KEY_W-1:0]      r_key;
    logic [POS_W-1:0]      r_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_seek_idx, n_seek_idx;
    logic                  r_seek_ok, n_seek_ok;

    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [HANDLE_W-1:0]   r_handle_out, n_handle_out;
    logic [KEY_W-1:0]      r_key_out, n_key_out;
    logic [CW-1:0]         r_count_out;

    logic                  in_fire, out_fire, out_free, apply;

    logic [KEY_W-1:0]      cell_key    [DEPTH];
    logic [HANDLE_W-1:0]   cell_handle [DEPTH];
    t_cell_flags           cell_flags  [DEPTH];
    t_cell_ctl             cell_ctl    [DEPTH];
    logic [DEPTH-1:0]      v, cur, ge, heq, keq;
    logic [DEPTH-1:0]      at_stop, after, ins_here, pre, hit, rd_sel;
    logic                  dup, eq_key, full, found, rd_any;

    logic [SW-1:0]         pos_x, sum;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;
    assign out_free = !r_out_valid || i_ready;
    assign apply    = (r_state == S_APPLY);
    assign o_ready  = (r_state == S_IDLE);

    // Control sequence.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_EVAL;
            S_EVAL:  if (out_free) n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd    <= i_command;
            r_handle <= i_handle;
            r_key    <= i_sort_key;
            r_pos    <= i_position;
        end
    end

    // Seek index: a negative position counts back from the count and is
    // clamped to the first entry.
    always_comb begin
        pos_x = {{(SW-POS_W){r_pos[POS_W-1]}}, r_pos};
        sum   = r_pos[POS_W-1] ? (pos_x + SW'(r_count)) : pos_x;
        n_seek_idx = sum[SW-1] ? '0 : sum[IW-1:0];
        n_seek_ok  = (n_seek_idx < IW'(r_count));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_seek_idx <= n_seek_idx;
            r_seek_ok  <= n_seek_ok;
        end
    end

    // Cell row.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0]    left_key,    right_key;
        logic [HANDLE_W-1:0] left_handle, right_handle;
        logic                left_valid,  right_valid, left_cur, right_cur;

        if (g == 0) begin : g_first
            assign left_key    = '0;
            assign left_handle = '0;
            assign left_valid  = 1'b0;
            assign left_cur    = 1'b0;
        end else begin : g_mid_l
            assign left_key    = cell_key[g-1];
            assign left_handle = cell_handle[g-1];
            assign left_valid  = v[g-1];
            assign left_cur    = cur[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key    = '0;
            assign right_handle = '0;
            assign right_valid  = 1'b0;
            assign right_cur    = 1'b0;
        end else begin : g_mid_r
            assign right_key    = cell_key[g+1];
            assign right_handle = cell_handle[g+1];
            assign right_valid  = v[g+1];
            assign right_cur    = cur[g+1];
        end

        skt_cell #(
            .KEY_W    (KEY_W),
            .HANDLE_W (HANDLE_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_eval         (r_state == S_EVAL),
            .i_key          (r_key),
            .i_handle       (r_handle),
            .i_ctl          (cell_ctl[g]),
            .i_left_key     (left_key),
            .i_left_handle  (left_handle),
            .i_left_valid   (left_valid),
            .i_left_cur     (left_cur),
            .i_right_key    (right_key),
            .i_right_handle (right_handle),
            .i_right_valid  (right_valid),
            .i_right_cur    (right_cur),
            .o_key          (cell_key[g]),
            .o_handle       (cell_handle[g]),
            .o_valid        (v[g]),
            .o_cur          (cur[g]),
            .o_flags        (cell_flags[g])
        );

        assign ge[g]  = cell_flags[g].ge;
        assign heq[g] = cell_flags[g].heq;
        assign keq[g] = cell_flags[g].keq;
        assign hit[g] = r_seek_ok && (r_seek_idx == IW'(g));
    end

    // Combine the flags: the insertion point is the first cell whose key is
    // not below the new key, or the first empty cell.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            at_stop[i]  = ge[i] && ((i == 0) ? 1'b1 : !ge[i-1]);
            after[i]    = ge[i] || !v[i];
            ins_here[i] = after[i] && ((i == 0) ? 1'b1 : !after[i-1]);
        end
        // Prefix OR of handle matches: every cell from the first match up.
        pre = heq;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            for (int i = DEPTH - 1; i >= s; i--) begin
                pre[i] = pre[i] | pre[i-s];
            end
        end
    end

    assign dup    = |(heq & (~ge | at_stop));
    assign eq_key = (r_cmd == CMD_ADD) && (|(at_stop & keq));
    assign full   = v[DEPTH-1];
    assign found  = pre[DEPTH-1];

    always_comb begin
        rd_sel = '0;
        if (r_cmd == CMD_SEEK) begin
            rd_sel = hit;
        end else if (r_cmd == CMD_TELL) begin
            rd_sel = cur & v;
        end else if (r_cmd == CMD_PEEK) begin
            rd_sel = {cur[DEPTH-2:0], 1'b0} & v;
        end
    end

    assign rd_any = |rd_sel;

    always_comb begin
        n_handle_out = '0;
        n_key_out    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_handle_out = n_handle_out | (cell_handle[i] & {HANDLE_W{rd_sel[i]}});
            n_key_out    = n_key_out | (cell_key[i] & {KEY_W{rd_sel[i]}});
        end
    end

    // Status, count and per-cell commands.
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i] = '{op: CELL_HOLD, cur: 1'b0};
        end
        unique case (r_cmd)
            CMD_ADD, CMD_FORCE_ADD: begin
                if (dup) begin
                    n_status = ST_DUP;
                end else if (eq_key) begin
                    n_status = ST_EQ_KEY;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ins_here[i]) begin
                            cell_ctl[i] = '{op: CELL_LOAD, cur: !v[0]};
                        end else if (after[i]) begin
                            cell_ctl[i] = '{op: CELL_LEFT, cur: 1'b0};
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count = r_count - CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (pre[i]) begin
                            cell_ctl[i] = '{op: CELL_RIGHT, cur: 1'b0};
                        end
                    end
                end
            end
            CMD_SEEK: begin
                if (!r_seek_ok) begin
                    n_status = ST_NO_ENTRY;
                end
                for (int i = 0; i < DEPTH; i++) begin
                    cell_ctl[i] = '{op: CELL_SEEK, cur: hit[i]};
                end
            end
            CMD_PEEK, CMD_TELL: begin
                if (!rd_any) begin
                    n_status = ST_NO_ENTRY;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
                for (int i = 0; i < DEPTH; i++) begin
                    cell_ctl[i] = '{op: CELL_CLEAR, cur: 1'b0};
                end
            end
            default: begin
            end
        endcase
        // Cells only change while the item is being applied.
        if (!apply) begin
            for (int i = 0; i < DEPTH; i++) begin
                cell_ctl[i] = '{op: CELL_HOLD, cur: 1'b0};
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (apply) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (apply) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_status     <= n_status;
            r_handle_out <= n_handle_out;
            r_key_out    <= n_key_out;
            r_count_out  <= n_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_handle_out  = r_handle_out;
    assign o_key_out     = r_key_out;
    assign o_entry_count = r_count_out;

    // The valid cells are always packed from the bottom and match the count.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(v) == r_count)
        else $error("valid cells disagree with the entry count");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((v & ~(v >> 1)) & ~(DEPTH'(1) << (r_count - CW'(1)))) == '0
        || r_count == '0)
        else $error("valid cells are not packed");

    a_cursor_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cur))
        else $error("more than one cursor mark");

    a_cursor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur & ~v) == '0)
        else $error("cursor on an empty cell");

endmodule

// ----- design/skt_cell.sv -----
// One slot of the sorted key table: an entry, its valid and cursor bits,
// and registered compare flags. Depends on skt_pkg.
module skt_cell import skt_pkg::*; #(
    parameter int KEY_W    = 32,
    parameter int HANDLE_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_eval,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HANDLE_W-1:0] i_handle,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_W-1:0]    i_left_key,
    input  logic [HANDLE_W-1:0] i_left_handle,
    input  logic                i_left_valid,
    input  logic                i_left_cur,
    input  logic [KEY_W-1:0]    i_right_key,
    input  logic [HANDLE_W-1:0] i_right_handle,
    input  logic                i_right_valid,
    input  logic                i_right_cur,
    output logic [KEY_W-1:0]    o_key,
    output logic [HANDLE_W-1:0] o_handle,
    output logic                o_valid,
    output logic                o_cur,
    output t_cell_flags         o_flags
);

    logic [KEY_W-1:0]    r_key,    n_key;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                r_valid,  n_valid;
    logic                r_cur,    n_cur;
    t_cell_flags         r_flags,  n_flags;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        n_valid  = r_valid;
        n_cur    = r_cur;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_LOAD: begin
                n_key    = i_key;
                n_handle = i_handle;
                n_valid  = 1'b1;
                n_cur    = i_ctl.cur;
            end
            CELL_LEFT: begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
                n_valid  = i_left_valid;
                n_cur    = i_left_cur;
            end
            CELL_RIGHT: begin
                n_key    = i_right_key;
                n_handle = i_right_handle;
                n_valid  = i_right_valid;
                n_cur    = i_right_cur;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
                n_cur   = 1'b0;
            end
            CELL_SEEK: begin
                n_cur = i_ctl.cur;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_flags = r_flags;
        if (i_eval) begin
            n_flags.ge  = r_valid && (r_key >= i_key);
            n_flags.heq = r_valid && (r_handle == i_handle);
            n_flags.keq = r_valid && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur   <= 1'b0;
            r_flags <= '0;
        end else begin
            r_valid <= n_valid;
            r_cur   <= n_cur;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_valid  = r_valid;
    assign o_cur    = r_cur;
    assign o_flags  = r_flags;

endmodule
